FILE: design/tdp_pkg.sv
// Shared constants and types for the trial-division prime tester.
`timescale 1ns / 1ps

package tdp_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    localparam logic [WIDTH-1:0] VAL_TWO   = WIDTH'(2);
    localparam logic [WIDTH-1:0] VAL_THREE = WIDTH'(3);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_WAIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] quo;
        logic [WIDTH-1:0] rem;
    } t_div_sts;

endpackage

FILE: design/tdp_divider.sv
// Radix-2 restoring divider: one quotient bit per cycle, dividend shifted out serially.
`timescale 1ns / 1ps

module tdp_divider
    import tdp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctl         i_ctl,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output t_div_sts         o_sts
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_dsr, n_dsr;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    // partial remainder with next dividend bit brought down
    assign trial = {r_rem, r_quo[WIDTH-1]};
    assign diff  = trial - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (!diff[WIDTH]) begin
                n_rem = diff[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                n_rem = trial[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_sts.done = r_done;
    assign o_sts.quo  = r_quo;
    assign o_sts.rem  = r_rem;

endmodule

FILE: design/tdp_ctrl.sv
// Sequencer: screens small and even values, then steps odd divisors through the divider.
`timescale 1ns / 1ps

module tdp_ctrl
    import tdp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_candidate,
    input  t_div_sts         i_div_sts,
    output t_div_ctl         o_div_ctl,
    output logic [WIDTH-1:0] o_dividend,
    output logic [WIDTH-1:0] o_divisor,
    output logic             o_busy,
    output logic             o_valid,
    output logic             o_is_prime
);

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_n, n_n;
    logic [WIDTH-1:0] r_d, n_d;
    logic             r_prime, n_prime;

    // next state and datapath registers
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_d     = r_d;
        n_prime = r_prime;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_n = i_candidate;
                    n_d = VAL_THREE;
                    if (i_candidate < VAL_TWO || !i_candidate[0]) begin
                        n_prime = (i_candidate == VAL_TWO);
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_LAUNCH;
                    end
                end
            end
            S_LAUNCH: n_state = S_WAIT;
            S_WAIT: begin
                if (i_div_sts.done) begin
                    if (r_d > i_div_sts.quo) begin
                        // divisor passed the square root: no factor found
                        n_prime = 1'b1;
                        n_state = S_RESULT;
                    end else if (i_div_sts.rem == '0) begin
                        n_prime = 1'b0;
                        n_state = S_RESULT;
                    end else begin
                        n_d     = r_d + VAL_TWO;
                        n_state = S_LAUNCH;
                    end
                end
            end
            S_RESULT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_div_ctl.start = 1'b0;
        o_busy          = 1'b1;
        o_valid         = 1'b0;
        case (r_state)
            S_IDLE:   o_busy          = 1'b0;
            S_LAUNCH: o_div_ctl.start = 1'b1;
            S_WAIT:   o_busy          = 1'b1;
            S_RESULT: o_valid         = 1'b1;
            default:  o_busy          = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n     <= n_n;
        r_d     <= n_d;
        r_prime <= n_prime;
    end

    assign o_dividend = r_n;
    assign o_divisor  = r_d;
    assign o_is_prime = r_prime;

endmodule

FILE: design/trial_division_prime_test.sv
// Top level of the trial-division prime tester.
// Values below three and even values go straight to the result; otherwise
// the divider runs once for each odd divisor tried.
// Throughput: one beat at a time; busy stays high through the strobe, low the cycle after.
// The worst case is a 32-bit prime, which runs the serial divider for every odd divisor up to its square root.
// Reset: synchronous, active low; clears the sequencer and divider control.
`timescale 1ns / 1ps

module trial_division_prime_test
    import tdp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_candidate,
    output logic             o_valid,
    output logic             o_is_prime
);

    t_div_ctl         div_ctl;
    t_div_sts         div_sts;
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;

    tdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_candidate (i_candidate),
        .i_div_sts   (div_sts),
        .o_div_ctl   (div_ctl),
        .o_dividend  (dividend),
        .o_divisor   (divisor),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .o_is_prime  (o_is_prime)
    );

    tdp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_sts      (div_sts)
    );

endmodule

FILE: design/tdp_checker.sv
// Port-level checks for the prime tester, bound to the top level.
`timescale 1ns / 1ps

module tdp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    // an accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted beat");

    // result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // result only while busy, and busy drops right after it
    a_strobe_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy ##1 !busy)
        else $error("result strobe not at end of busy period");

    // busy only falls after a result
    a_fall_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_valid))
        else $error("busy dropped without a result");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

FILE: tb/testbench.sv
// Testbench for trial_division_prime_test: queued candidates, predicted verdicts, strobe checks.
`timescale 1ns / 1ps

module testbench;
    import tdp_pkg::*;

    typedef struct {
        logic [WIDTH-1:0] value;
        bit               settle_first;  // hold off until every verdict is back
    } candidate_beat_t;

    typedef struct {
        logic [WIDTH-1:0] value;
        bit               prime;
    } verdict_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [WIDTH-1:0] i_candidate;
    logic             o_valid;
    logic             o_is_prime;

    candidate_beat_t candidates_to_send[$];
    verdict_t        verdicts_due[$];
    candidate_beat_t next_beat;
    verdict_t        oldest_verdict;

    bit          took;
    int unsigned beats_sent;
    int unsigned beats_taken;
    int unsigned verdicts_seen;
    int unsigned primes_seen;
    int unsigned mismatches;
    int unsigned most_tries;
    longint      cycles;
    longint      cycle_budget;
    longint      cycle_limit;

    trial_division_prime_test DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_candidate (i_candidate),
        .o_valid     (o_valid),
        .o_is_prime  (o_is_prime)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Odd divisors from three while d*d <= n; tries counts divisors attempted.
    function automatic bit prime_by_division(input logic [WIDTH-1:0] n,
                                             output int unsigned tries);
        longint unsigned v;
        longint unsigned d;
        v = 64'(n);
        tries = 0;
        if (n < VAL_TWO) return 1'b0;
        if (v[0] == 1'b0) return n == VAL_TWO;
        for (d = 64'(VAL_THREE); d <= v / d; d += 2) begin
            tries++;
            if (v % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic queue_candidate(input logic [WIDTH-1:0] value, input bit settle);
        candidate_beat_t beat;
        int unsigned     tries;
        bit              unused_verdict;
        unused_verdict = prime_by_division(value, tries);
        beat.value = value;
        beat.settle_first = settle;
        candidates_to_send = {candidates_to_send, beat};
        cycle_budget += 2 + longint'(tries) * (WIDTH + 2) + 200;
        if (tries > most_tries) most_tries = tries;
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Driver: new beat or idle at the falling edge, start held until taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !took) begin
            // beat still waiting for busy to drop
        end else if (candidates_to_send.size() == 0) begin
            start <= 1'b0;
            i_candidate <= WIDTH'($urandom());
        end else if (candidates_to_send[0].settle_first && verdicts_due.size() != 0) begin
            start <= 1'b0;
            i_candidate <= WIDTH'($urandom());
        end else if (!(beats_sent >= 50 && beats_sent < 75) && $urandom_range(99) < 23) begin
            start <= 1'b0;
            i_candidate <= WIDTH'($urandom());
        end else begin
            next_beat = candidates_to_send.pop_front();
            i_candidate <= next_beat.value;
            start <= 1'b1;
            beats_sent <= beats_sent + 1;
        end
    end

    // Monitor: results are checked before the beat taken on the same edge is queued.
    always @(posedge i_clk) begin
        took <= i_rst_n && start && !busy;
        if (i_rst_n && o_valid) begin
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result, is_prime=%0b", o_is_prime));
            end else begin
                oldest_verdict = verdicts_due.pop_front();
                if (o_is_prime !== oldest_verdict.prime)
                    report_mismatch($sformatf("candidate %0d: is_prime=%0b, want %0b",
                        oldest_verdict.value, o_is_prime, oldest_verdict.prime));
            end
        end
        if (i_rst_n && start && !busy) begin
            int unsigned tries;
            verdict_t    fresh;
            fresh.value = i_candidate;
            fresh.prime = prime_by_division(i_candidate, tries);
            if (fresh.prime) primes_seen++;
            verdicts_due = {verdicts_due, fresh};
            beats_taken++;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > cycle_limit) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycles, verdicts_due.size());
            $display("trial_division_prime_test test failed");
            $finish;
        end
    end

    initial begin
        logic [WIDTH-1:0] value;
        int unsigned      tries;
        bit               unused_verdict;
        int unsigned      pick;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_candidate = '0;
        took = 1'b0;
        beats_sent = 0;
        beats_taken = 0;
        verdicts_seen = 0;
        primes_seen = 0;
        mismatches = 0;
        most_tries = 0;
        cycles = 0;
        cycle_budget = 0;
        cycle_limit = 64'h7fff_ffff_ffff;

        // zero, one, two, three, small squares, field extremes, largest primes
        queue_candidate('0, 1'b0);
        queue_candidate(WIDTH'(1), 1'b0);
        queue_candidate(WIDTH'(2), 1'b0);
        queue_candidate(WIDTH'(3), 1'b0);
        queue_candidate(WIDTH'(4), 1'b0);
        queue_candidate(WIDTH'(5), 1'b0);
        queue_candidate(WIDTH'(9), 1'b0);
        queue_candidate(WIDTH'(15), 1'b0);
        queue_candidate(WIDTH'(25), 1'b0);
        queue_candidate(WIDTH'(49), 1'b0);
        queue_candidate(WIDTH'(121), 1'b0);
        queue_candidate(WIDTH'(1042441), 1'b0);     // 1021 squared
        queue_candidate(WIDTH'(65521), 1'b0);
        queue_candidate(WIDTH'(65537), 1'b0);
        queue_candidate('1, 1'b0);
        queue_candidate({{(WIDTH-1){1'b1}}, 1'b0}, 1'b0);
        queue_candidate({1'b1, {(WIDTH-1){1'b0}}}, 1'b0);
        queue_candidate(WIDTH'(32'h5555_5555), 1'b0);
        queue_candidate(WIDTH'(32'haaaa_aaaa), 1'b0);
        queue_candidate(WIDTH'(32'd4294967291), 1'b1); // largest 32-bit prime
        queue_candidate(WIDTH'(7), 1'b1);

        for (int i = 0; i < 80; i++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                value = WIDTH'($urandom_range(4095));
            end else if (pick < 75) begin
                value = WIDTH'($urandom_range(32'h0010_0000));
            end else begin
                // full width, but only values that fall to a small divisor
                do begin
                    value = WIDTH'($urandom());
                    unused_verdict = prime_by_division(value, tries);
                end while (tries > 200);
            end
            queue_candidate(value, i == 30 || i == 70);
        end
        cycle_limit = 3 * cycle_budget + 20000;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (candidates_to_send.size() != 0 || start || verdicts_due.size() != 0);
        repeat (4 * (WIDTH + 2) + 8) @(posedge i_clk);

        $display("%0d beats taken, %0d verdicts checked (%0d prime), up to %0d divisors tried",
                 beats_taken, verdicts_seen, primes_seen, most_tries);
        $display("%0d mismatches in %0d cycles", mismatches, cycles);
        if (mismatches == 0) begin
            $display("trial_division_prime_test test passed");
        end else begin
            $display("trial_division_prime_test test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/tdp_pkg.sv
design/tdp_divider.sv
design/tdp_ctrl.sv
design/trial_division_prime_test.sv
design/tdp_checker.sv
tb/testbench.sv
